>>> sv/rws_pkg.sv
// shared types, codes and default sizes for the roulette wheel selector
`default_nettype none

package rws_pkg;

    localparam int MAX_POPULATION_DEF = 64;
    localparam int FITNESS_BITS_DEF   = 32;
    localparam int FRACTION_BITS_DEF  = 15;

    localparam logic [1:0] CMD_CLEAR  = 2'd0;
    localparam logic [1:0] CMD_APPEND = 2'd1;
    localparam logic [1:0] CMD_DRAW   = 2'd2;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_FULL  = 2'd1;
    localparam logic [1:0] STATUS_NOHIT = 2'd2;

    typedef struct packed {
        logic [1:0]  command;
        logic [31:0] fitness_value;
        logic [14:0] random_fraction;
    } cmd_item_t;

    typedef struct packed {
        logic [1:0] status;
        logic [6:0] selected_index;
        logic [6:0] entries_held;
    } rsp_item_t;

    typedef struct packed {
        logic load_product;
        logic load_target;
    } scale_ctrl_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCALE,
        ST_SEARCH,
        ST_FINISH
    } state_t;

endpackage

`default_nettype wire

>>> sv/rws_ram.sv
// generic single-port-write ram with registered read
`default_nettype none

module rws_ram #(
    parameter int WIDTH = 38,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

>>> sv/rws_scale.sv
// scales the fitness total by the random fraction in two registered steps
`default_nettype none

module rws_scale #(
    parameter int FRACTION_BITS = 15,
    parameter int SUM_BITS      = 38
) (
    input  wire logic                     clk,
    input  wire rws_pkg::scale_ctrl_t     ctrl,
    input  wire logic [FRACTION_BITS-1:0] fraction,
    input  wire logic [SUM_BITS-1:0]      total,
    output logic      [SUM_BITS-1:0]      target
);

    import rws_pkg::*;

    localparam int LO_BITS   = (SUM_BITS + 1) / 2;
    localparam int HI_BITS   = SUM_BITS - LO_BITS;
    localparam int PL_BITS   = FRACTION_BITS + LO_BITS;
    localparam int PH_BITS   = FRACTION_BITS + HI_BITS;
    localparam int FULL_BITS = FRACTION_BITS + SUM_BITS;

    logic [PL_BITS-1:0]   p_lo_reg, p_lo_next;
    logic [PH_BITS-1:0]   p_hi_reg, p_hi_next;
    logic [SUM_BITS-1:0]  target_reg, target_next;
    logic [FULL_BITS-1:0] product;

    // split multiply: low and high halves of the total
    always_comb
    begin
        p_lo_next = {{LO_BITS{1'b0}}, fraction} * {{FRACTION_BITS{1'b0}}, total[LO_BITS-1:0]};
        p_hi_next = {{HI_BITS{1'b0}}, fraction} *
                    {{FRACTION_BITS{1'b0}}, total[SUM_BITS-1:LO_BITS]};
        product     = {p_hi_reg, {LO_BITS{1'b0}}} + FULL_BITS'(p_lo_reg);
        target_next = product[FRACTION_BITS +: SUM_BITS];
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load_product)
        begin
            p_lo_reg <= p_lo_next;
            p_hi_reg <= p_hi_next;
        end
        if (ctrl.load_target)
        begin
            target_reg <= target_next;
        end
    end

    assign target = target_reg;

endmodule

`default_nettype wire

>>> sv/roulette_wheel_selector.sv
// roulette wheel selector: running-sum table with scaled binary-search draw
// clear, append and command 3: result is registered in res_reg, then moved to the output register in ST_FINISH
// draw: ST_SCALE, then binary-search steps in ST_SEARCH (about log2 of entries), then ST_FINISH
// each search step is one registered read of the running-sum ram
// one transaction at a time: the next is taken once the result moves to the output register
// reset clears the entry count and total; ram contents are unused until appended
`default_nettype none

module roulette_wheel_selector #(
    parameter int MAX_POPULATION = rws_pkg::MAX_POPULATION_DEF,
    parameter int FITNESS_BITS   = rws_pkg::FITNESS_BITS_DEF,
    parameter int FRACTION_BITS  = rws_pkg::FRACTION_BITS_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cmd_valid,
    output logic                    cmd_ready,
    input  wire rws_pkg::cmd_item_t cmd,
    output logic                    rsp_valid,
    input  wire logic               rsp_ready,
    output rws_pkg::rsp_item_t      rsp
);

    import rws_pkg::*;

    localparam int IDX_BITS = (MAX_POPULATION > 1) ? $clog2(MAX_POPULATION) : 1;
    localparam int CNT_BITS = $clog2(MAX_POPULATION + 1);
    localparam int SUM_BITS = FITNESS_BITS + IDX_BITS;

    state_t              state_reg, state_next;
    logic [CNT_BITS-1:0] count_reg, count_next;
    logic [SUM_BITS-1:0] total_reg, total_next;
    logic [IDX_BITS-1:0] lo_reg, lo_next;
    logic [IDX_BITS-1:0] hi_reg, hi_next;
    logic [IDX_BITS-1:0] mid_reg, mid_next;
    rsp_item_t           res_reg, res_next;
    logic                rsp_valid_reg, rsp_valid_next;
    rsp_item_t           rsp_reg, rsp_next;

    logic [IDX_BITS-1:0] lo_step, hi_step;
    logic [SUM_BITS-1:0] appended_sum;
    logic [6:0]          entries;
    logic                ram_we;
    logic [IDX_BITS-1:0] ram_raddr;
    logic [SUM_BITS-1:0] ram_rdata;
    logic [SUM_BITS-1:0] target;
    scale_ctrl_t         scale_ctrl;

    rws_ram #(
        .WIDTH (SUM_BITS),
        .DEPTH (MAX_POPULATION)
    ) u_sum_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (count_reg[IDX_BITS-1:0]),
        .wdata (appended_sum),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    rws_scale #(
        .FRACTION_BITS (FRACTION_BITS),
        .SUM_BITS      (SUM_BITS)
    ) u_scale (
        .clk      (clk),
        .ctrl     (scale_ctrl),
        .fraction (FRACTION_BITS'(cmd.random_fraction)),
        .total    (total_reg),
        .target   (target)
    );

    assign appended_sum = total_reg + SUM_BITS'(FITNESS_BITS'(cmd.fitness_value));
    assign entries      = 7'(count_reg);
    assign cmd_ready    = (state_reg == ST_IDLE);
    assign rsp_valid    = rsp_valid_reg;
    assign rsp          = rsp_reg;

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        total_next     = total_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        mid_next       = mid_reg;
        res_next       = res_reg;
        rsp_valid_next = rsp_valid_reg;
        rsp_next       = rsp_reg;
        ram_we         = 1'b0;
        ram_raddr      = mid_reg;
        scale_ctrl     = '0;
        lo_step        = lo_reg;
        hi_step        = hi_reg;

        if (rsp_valid_reg && rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    res_next   = '{status: STATUS_OK, selected_index: 7'd0, entries_held: entries};
                    state_next = ST_FINISH;
                    case (cmd.command)
                        CMD_CLEAR:
                        begin
                            count_next            = '0;
                            total_next            = '0;
                            res_next.entries_held = 7'd0;
                        end
                        CMD_APPEND:
                        begin
                            if (count_reg >= CNT_BITS'(MAX_POPULATION))
                            begin
                                res_next.status = STATUS_FULL;
                            end
                            else
                            begin
                                ram_we                = 1'b1;
                                total_next            = appended_sum;
                                count_next            = count_reg + CNT_BITS'(1);
                                res_next.entries_held = 7'(count_reg + CNT_BITS'(1));
                            end
                        end
                        CMD_DRAW:
                        begin
                            if (count_reg == '0 || total_reg == '0)
                            begin
                                res_next.status = STATUS_NOHIT;
                            end
                            else
                            begin
                                scale_ctrl.load_product = 1'b1;
                                state_next              = ST_SCALE;
                            end
                        end
                        default:
                        begin
                            res_next.status = STATUS_OK;
                        end
                    endcase
                end
            end
            ST_SCALE:
            begin
                scale_ctrl.load_target = 1'b1;
                if (count_reg == CNT_BITS'(1))
                begin
                    res_next   = '{status: STATUS_OK, selected_index: 7'd1, entries_held: entries};
                    state_next = ST_FINISH;
                end
                else
                begin
                    lo_next    = '0;
                    hi_next    = IDX_BITS'(count_reg - CNT_BITS'(1));
                    mid_next   = hi_next >> 1;
                    ram_raddr  = mid_next;
                    state_next = ST_SEARCH;
                end
            end
            ST_SEARCH:
            begin
                if (ram_rdata > target)
                begin
                    lo_step = lo_reg;
                    hi_step = mid_reg;
                end
                else
                begin
                    lo_step = mid_reg + IDX_BITS'(1);
                    hi_step = hi_reg;
                end
                lo_next = lo_step;
                hi_next = hi_step;
                if (lo_step < hi_step)
                begin
                    mid_next  = lo_step + ((hi_step - lo_step) >> 1);
                    ram_raddr = mid_next;
                end
                else
                begin
                    res_next = '{status:         STATUS_OK,
                                 selected_index: 7'(CNT_BITS'(lo_step) + CNT_BITS'(1)),
                                 entries_held:   entries};
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_valid_next = 1'b1;
                    rsp_next       = res_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            total_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            total_reg     <= total_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg  <= lo_next;
        hi_reg  <= hi_next;
        mid_reg <= mid_next;
        res_reg <= res_next;
        rsp_reg <= rsp_next;
    end

endmodule

`default_nettype wire

>>> tb/sv/tb.sv
// self-checking testbench for the roulette wheel selector: table building, draws and stalls
`timescale 1ns / 100ps

module tb;
    import rws_pkg::*;

    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam int TABLE_DEPTH = MAX_POPULATION_DEF;
    localparam int RANDOM_ITEMS = 280;
    localparam int HOLD_OFF_CYCLES = 80;
    localparam int DRAIN_CYCLES = 30;
    localparam int PRINT_LIMIT = 40;

    logic clk = 1'b0;
    logic rst_n;
    logic cmd_valid;
    logic cmd_ready;
    cmd_item_t cmd;
    logic rsp_valid;
    logic rsp_ready;
    rsp_item_t rsp;

    roulette_wheel_selector DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    logic [37:0] sum_table [0:TABLE_DEPTH-1];
    logic [6:0]  table_count;
    logic [37:0] table_total;
    rsp_item_t   expected_rsp_q[$];
    rsp_item_t   oldest_rsp;

    int error_count;
    int sent_count;
    int checked_count;
    int clear_count;
    int append_count;
    int full_count;
    int draw_count;
    int hit_count;
    int nohit_count;
    int unused_count;
    bit gapless;
    int hold_request;
    bit hold_taken;
    int longest_hold;

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        error_count++;
        if (error_count <= PRINT_LIMIT)
        begin
            $display("mismatch %0s: got %0d expected %0d (response %0d, t=%0t)",
                     what, got, want, checked_count, $realtime);
        end
    endtask

    function automatic rsp_item_t predict_selection(cmd_item_t item);
        rsp_item_t   r;
        logic [52:0] product;
        logic [37:0] target;
        int          k;
        r = '0;
        case (item.command)
            CMD_CLEAR:
            begin
                table_count = '0;
                table_total = '0;
                clear_count++;
            end
            CMD_APPEND:
            begin
                append_count++;
                if (table_count >= TABLE_DEPTH)
                begin
                    r.status = STATUS_FULL;
                    full_count++;
                end
                else
                begin
                    table_total = table_total + 38'(item.fitness_value);
                    sum_table[table_count] = table_total;
                    table_count = table_count + 7'd1;
                end
            end
            CMD_DRAW:
            begin
                draw_count++;
                if (table_count == 0 || table_total == 0)
                begin
                    r.status = STATUS_NOHIT;
                    nohit_count++;
                end
                else
                begin
                    product = 53'(item.random_fraction) * 53'(table_total);
                    target = 38'(product >> FRACTION_BITS_DEF);
                    for (k = 0; k < table_count - 1 && sum_table[k] <= target; k++)
                    begin
                    end
                    r.selected_index = 7'(k + 1);
                    hit_count++;
                end
            end
            default:
            begin
                unused_count++;
            end
        endcase
        r.entries_held = table_count;
        return r;
    endfunction

    function automatic logic [31:0] pick_fitness();
        case ($urandom_range(0, 9))
            0: return 32'd0;
            1: return 32'hFFFF_FFFF;
            2: return 32'($urandom_range(1, 15));
            3, 4, 5: return 32'($urandom_range(1, 1000));
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [14:0] pick_fraction();
        case ($urandom_range(0, 15))
            0: return 15'd0;
            1: return 15'h7FFF;
            default: return 15'($urandom_range(0, 32767));
        endcase
    endfunction

    task automatic send_command(logic [1:0] op, logic [31:0] fitness, logic [14:0] fraction);
        cmd_item_t item;
        rsp_item_t predicted;
        int        gap;
        item.command = op;
        item.fitness_value = fitness;
        item.random_fraction = fraction;
        gap = gapless ? 0 : $urandom_range(0, 11);
        if (gap > 0)
        begin
            cmd_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_valid <= 1'b1;
        cmd <= item;
        do
            @(posedge clk);
        while (!cmd_ready);
        predicted = predict_selection(item);
        expected_rsp_q = {expected_rsp_q, predicted};
        sent_count++;
    endtask

    initial
    begin : rsp_sink
        int stall;
        rsp_ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_request > 0)
            begin
                stall = hold_request;
                hold_request = 0;
                hold_taken = 1'b1;
            end
            else
            begin
                stall = gapless ? 0 : $urandom_range(0, 11);
            end
            if (stall > 0)
            begin
                rsp_ready <= 1'b0;
                for (int c = 0; c < stall; c++)
                begin
                    @(posedge clk);
                    if (c + 1 > longest_hold)
                        longest_hold = c + 1;
                end
            end
            rsp_ready <= 1'b1;
            do
                @(posedge clk);
            while (!rsp_valid && hold_request == 0);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (expected_rsp_q.size() == 0)
            begin
                report_mismatch("transaction with nothing expected", 64'(rsp), 64'd0);
            end
            else
            begin
                oldest_rsp = expected_rsp_q.pop_front();
                if (rsp.status !== oldest_rsp.status)
                    report_mismatch("status", 64'(rsp.status), 64'(oldest_rsp.status));
                if (rsp.selected_index !== oldest_rsp.selected_index)
                    report_mismatch("selected_index", 64'(rsp.selected_index),
                                    64'(oldest_rsp.selected_index));
                if (rsp.entries_held !== oldest_rsp.entries_held)
                    report_mismatch("entries_held", 64'(rsp.entries_held),
                                    64'(oldest_rsp.entries_held));
            end
            checked_count++;
        end
    end

    task automatic test_empty_and_zero_sum();
        send_command(CMD_CLEAR, $urandom, 15'($urandom));
        send_command(CMD_DRAW, 32'd0, 15'd0);
        send_command(CMD_DRAW, 32'd0, 15'h7FFF);
        send_command(CMD_UNUSED, 32'hFFFF_FFFF, 15'h7FFF);
        send_command(CMD_APPEND, 32'd0, 15'd0);
        send_command(CMD_DRAW, 32'd0, 15'd12345);
        send_command(CMD_APPEND, 32'd0, 15'h7FFF);
        send_command(CMD_DRAW, 32'hFFFF_FFFF, 15'h7FFF);
    endtask

    task automatic test_field_extremes();
        send_command(CMD_CLEAR, 32'd0, 15'd0);
        send_command(CMD_APPEND, 32'hFFFF_FFFF, 15'd0);
        send_command(CMD_APPEND, 32'd0, 15'd0);
        send_command(CMD_APPEND, 32'd1, 15'd0);
        send_command(CMD_DRAW, 32'd0, 15'd0);
        send_command(CMD_DRAW, 32'd0, 15'h7FFF);
        send_command(CMD_APPEND, 32'hFFFF_FFFF, 15'h7FFF);
        send_command(CMD_DRAW, 32'd0, 15'h4000);
        send_command(CMD_DRAW, 32'd0, 15'h3FFF);
        send_command(CMD_DRAW, 32'd0, 15'h7FFF);
        send_command(CMD_UNUSED, $urandom, 15'($urandom));
        send_command(CMD_DRAW, 32'd0, 15'd1);
    endtask

    task automatic test_full_table();
        send_command(CMD_CLEAR, 32'd0, 15'd0);
        repeat (TABLE_DEPTH) send_command(CMD_APPEND, 32'hFFFF_FFFF, 15'd0);
        send_command(CMD_APPEND, 32'hFFFF_FFFF, 15'd0);
        send_command(CMD_APPEND, 32'd0, 15'd0);
        send_command(CMD_DRAW, 32'd0, 15'd0);
        send_command(CMD_DRAW, 32'd0, 15'h7FFF);
        send_command(CMD_DRAW, 32'd0, 15'h4000);
        send_command(CMD_CLEAR, 32'd0, 15'd0);
        send_command(CMD_DRAW, 32'd0, 15'h7FFF);
    endtask

    task automatic test_output_backpressure();
        send_command(CMD_CLEAR, 32'd0, 15'd0);
        repeat (4) send_command(CMD_APPEND, pick_fitness(), 15'd0);
        hold_taken = 1'b0;
        hold_request = HOLD_OFF_CYCLES;
        wait (hold_taken);
        gapless = 1'b1;
        repeat (24) send_command(CMD_DRAW, 32'd0, pick_fraction());
        gapless = 1'b0;
    endtask

    task automatic test_random_sessions();
        int first;
        int steps;
        int pick;
        first = sent_count;
        while (sent_count - first < RANDOM_ITEMS)
        begin
            gapless = ($urandom_range(0, 4) == 0);
            send_command(CMD_CLEAR, $urandom, 15'($urandom));
            pick = $urandom_range(0, 9);
            if (pick == 0)
                repeat ($urandom_range(40, 70)) send_command(CMD_APPEND, pick_fitness(),
                                                            15'($urandom));
            steps = $urandom_range(4, 20);
            repeat (steps)
            begin
                pick = $urandom_range(0, 19);
                if (pick < 8)
                    send_command(CMD_APPEND, pick_fitness(), 15'($urandom));
                else if (pick < 19)
                    send_command(CMD_DRAW, $urandom, pick_fraction());
                else
                    send_command(2'($urandom_range(0, 3)), $urandom, 15'($urandom));
            end
        end
        gapless = 1'b0;
    endtask

    initial
    begin
        rst_n <= 1'b0;
        cmd_valid <= 1'b0;
        cmd <= '0;
        table_count = '0;
        table_total = '0;
        hold_request = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_and_zero_sum();
        test_field_extremes();
        test_full_table();
        test_output_backpressure();
        test_random_sessions();

        cmd_valid <= 1'b0;
        while (expected_rsp_q.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (expected_rsp_q.size() != 0)
            report_mismatch("expected responses never arrived", 64'(0),
                            64'(expected_rsp_q.size()));

        $display("%0d transactions: %0d clear, %0d append (%0d on a full table), %0d unused",
                 sent_count, clear_count, append_count, full_count, unused_count);
        $display("%0d draws (%0d hits, %0d with no hit), receiver held off up to %0d cycles",
                 draw_count, hit_count, nohit_count, longest_hold);
        if (error_count == 0)
        begin
            $display("** roulette_wheel_selector: PASSED **");
        end
        else
        begin
            $display("%0d mismatches", error_count);
            $display("** roulette_wheel_selector: FAILED **");
        end
        $finish;
    end

    initial
    begin
        #2ms;
        $display("timeout with %0d responses outstanding", expected_rsp_q.size());
        $display("** roulette_wheel_selector: FAILED **");
        $finish;
    end

endmodule
